// ----- sv/dq_pkg.sv -----
// Package for the double-ended queue: opcodes, status codes, beat payload types
// and the command struct between the controller and the datapath.
// No dependencies.
package dq_pkg;

  localparam int DEPTH_DEFAULT = 1024;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK  = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [10:0]        count;
    logic               is_empty;
  } out_item_t;

  typedef struct packed {
    logic capture;  // latch the accepted input beat
    logic exec;     // memory access and pointer/count update
    logic load;     // move the result into the output register
  } cmd_t;

endpackage

// ----- sv/dq_ctrl.sv -----
// Controller for the double-ended queue: sequences capture, execute and load,
// and owns the output valid flag. Depends on dq_pkg.
module dq_ctrl (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output dq_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    cmd.load    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // wait here until the previous result beat has left
        if (slot_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/dq_datapath.sv -----
// Datapath for the double-ended queue: entry memory, front/back pointers,
// entry count and the result register. Depends on dq_pkg.
module dq_datapath #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  dq_pkg::cmd_t     cmd,
  input  dq_pkg::in_item_t in_data,
  output dq_pkg::out_item_t out_data
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int CWX = (CW > 11) ? CW : 11;
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_data;

  logic [2:0]    op_q;
  logic [31:0]   val_q;
  logic [PW-1:0] front;
  logic [PW-1:0] back;
  logic [CW-1:0] cnt;
  logic [1:0]    res_status;
  logic          res_use_mem;

  logic [PW-1:0] front_inc, front_dec, back_inc, back_dec;
  logic          is_full, is_zero;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_addr;
  logic [PW-1:0] front_next, back_next;
  logic [CW-1:0] cnt_next;
  logic [1:0]    status_next;
  logic [CWX-1:0] cnt_ext;

  assign front_inc = (front == LAST) ? '0 : front + PW'(1);
  assign front_dec = (front == '0) ? LAST : front - PW'(1);
  assign back_inc  = (back == LAST) ? '0 : back + PW'(1);
  assign back_dec  = (back == '0) ? LAST : back - PW'(1);
  assign is_full   = (cnt == FULL_CNT);
  assign is_zero   = (cnt == '0);

  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = front;
    front_next  = front;
    back_next   = back;
    cnt_next    = cnt;
    status_next = dq_pkg::ST_OK;
    unique case (op_q) inside
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (is_full) begin
          status_next = dq_pkg::ST_FULL;
        end else if (op_q == dq_pkg::OP_PUSH_FRONT) begin
          mem_we     = 1'b1;
          mem_addr   = front_dec;
          front_next = front_dec;
          cnt_next   = cnt + CW'(1);
        end else begin
          mem_we    = 1'b1;
          mem_addr  = back;
          back_next = back_inc;
          cnt_next  = cnt + CW'(1);
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
        if (is_zero) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          mem_re   = 1'b1;
          mem_addr = front;
          if (op_q == dq_pkg::OP_POP_FRONT) begin
            front_next = front_inc;
            cnt_next   = cnt - CW'(1);
          end
        end
      end
      dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
        if (is_zero) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          mem_re   = 1'b1;
          mem_addr = back_dec;
          if (op_q == dq_pkg::OP_POP_BACK) begin
            back_next = back_dec;
            cnt_next  = cnt - CW'(1);
          end
        end
      end
      default: ;  // unused opcodes: no operation
    endcase
  end

  // single-port entry memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      mem[mem_addr] <= val_q;
    end
    if (cmd.exec && mem_re) begin
      rd_data <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      cnt   <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      back  <= back_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= in_data.opcode;
      val_q <= in_data.push_value;
    end
    if (cmd.exec) begin
      res_status  <= status_next;
      res_use_mem <= mem_re;
    end
  end

  assign cnt_ext = CWX'(cnt);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (res_use_mem) begin
        out_data.read_value <= rd_data;
      end else if (res_status == dq_pkg::ST_EMPTY) begin
        out_data.read_value <= -32'sd1;
      end else begin
        out_data.read_value <= '0;
      end
      out_data.status   <= res_status;
      out_data.count    <= cnt_ext[10:0];
      out_data.is_empty <= is_zero;
    end
  end

endmodule

// ----- sv/double_ended_queue_top.sv -----
// Double-ended queue, a circular buffer of DEPTH 32-bit entries with push,
// pop and peek at both ends; every input beat gives one result beat. Each
// item passes through capture, which latches the accepted beat, execute,
// which does the single-port entry memory access with pointer and count
// update, and load, which moves the result into the output register once
// the previous result beat has left; no new item is accepted until the load.
// A push into a full queue is dropped with status full; a pop or peek on an
// empty queue returns -1 with status empty. The memory needs no clearing
// pass after reset.
// Depends on dq_pkg, dq_ctrl, dq_datapath.
module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dq_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dq_pkg::out_item_t out_data
);

  dq_pkg::cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

// ----- sv/dq_checker.sv -----
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on dq_pkg and double_ended_queue_top.
module dq_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input dq_pkg::in_item_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input dq_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // one item at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_empty |-> out_data.count == 11'd0)
    else $error("empty flag with nonzero count");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == dq_pkg::ST_EMPTY |->
      out_data.read_value == -32'sd1 && out_data.is_empty)
    else $error("bad empty result");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == dq_pkg::ST_FULL |->
      out_data.read_value == 32'sd0 && !out_data.is_empty)
    else $error("bad full result");

endmodule

bind double_ended_queue_top dq_checker u_dq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- test/tb_double_ended_queue_top.sv -----
// Testbench for double_ended_queue_top: directed and random deque operations, with a
// local model of the circular store that predicts every result beat.
// Depends on dq_pkg and double_ended_queue_top.
module tb_double_ended_queue_top;

  localparam int DEPTH = dq_pkg::DEPTH_DEFAULT;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_REPLY = 500;
  localparam int DRAIN_CYCLES = 12;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  dq_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dq_pkg::out_item_t out_data;

  double_ended_queue_top #(.DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // model of the store
  logic [31:0] deque_entries [DEPTH];
  logic [PTR_W-1:0] head_idx = '0;
  logic [PTR_W-1:0] tail_idx = '0;
  int unsigned entry_total = 0;

  dq_pkg::out_item_t predicted_replies[$];
  dq_pkg::in_item_t op_backlog[$];
  int unsigned planned_total = 0;  // fill level as the stimulus planner sees it

  int error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned replies_seen = 0;
  int burst_left = 1;
  int idle_left = 0;
  int seg_left = 0;
  int hold_left = 0;
  int unsigned ready_pct = 100;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [PTR_W-1:0] next_idx(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] prev_idx(logic [PTR_W-1:0] p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : p - 1'b1;
  endfunction

  function automatic void apply_deque_op(dq_pkg::in_item_t item);
    dq_pkg::out_item_t reply;
    logic [PTR_W-1:0] last_idx;
    reply = '0;
    reply.status = dq_pkg::ST_OK;
    case (item.opcode)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        if (entry_total >= DEPTH) begin
          reply.status = dq_pkg::ST_FULL;
        end else if (item.opcode == dq_pkg::OP_PUSH_FRONT) begin
          head_idx = prev_idx(head_idx);
          deque_entries[head_idx] = item.push_value;
          entry_total++;
        end else begin
          deque_entries[tail_idx] = item.push_value;
          tail_idx = next_idx(tail_idx);
          entry_total++;
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
        if (entry_total == 0) begin
          reply.read_value = -1;
          reply.status = dq_pkg::ST_EMPTY;
        end else begin
          reply.read_value = deque_entries[head_idx];
          if (item.opcode == dq_pkg::OP_POP_FRONT) begin
            head_idx = next_idx(head_idx);
            entry_total--;
          end
        end
      end
      dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
        if (entry_total == 0) begin
          reply.read_value = -1;
          reply.status = dq_pkg::ST_EMPTY;
        end else begin
          last_idx = prev_idx(tail_idx);
          reply.read_value = deque_entries[last_idx];
          if (item.opcode == dq_pkg::OP_POP_BACK) begin
            tail_idx = last_idx;
            entry_total--;
          end
        end
      end
      default: ;  // spare opcodes leave the state alone
    endcase
    reply.count = entry_total[10:0];
    reply.is_empty = (entry_total == 0);
    predicted_replies.insert(predicted_replies.size(), reply);
  endfunction

  function automatic void plan_op(logic [2:0] op, logic [31:0] value);
    dq_pkg::in_item_t item;
    item.opcode = op;
    item.push_value = value;
    op_backlog.insert(op_backlog.size(), item);
    if ((op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_BACK) &&
        planned_total < DEPTH) begin
      planned_total++;
    end else if ((op == dq_pkg::OP_POP_FRONT || op == dq_pkg::OP_POP_BACK) &&
                 planned_total > 0) begin
      planned_total--;
    end
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  // push_pct of the beats are pushes, 3 percent use spare opcodes, the rest pop or peek
  function automatic logic [2:0] rand_op(int unsigned push_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
    if (r < 3 + push_pct) begin
      return $urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
    end
    case ($urandom_range(0, 5))
      0, 1: return dq_pkg::OP_POP_FRONT;
      2, 3: return dq_pkg::OP_POP_BACK;
      4: return dq_pkg::OP_PEEK_FRONT;
      default: return dq_pkg::OP_PEEK_BACK;
    endcase
  endfunction

  // stimulus plan, reset and end of run
  initial begin
    int k;
    plan_op(dq_pkg::OP_POP_FRONT, 32'h1234_5678);
    plan_op(dq_pkg::OP_POP_BACK, 32'hFFFF_FFFF);
    plan_op(dq_pkg::OP_PEEK_FRONT, 32'h8000_0000);
    plan_op(dq_pkg::OP_PEEK_BACK, 32'h7FFF_FFFF);
    plan_op(OP_SPARE_6, 32'hA5A5_A5A5);
    plan_op(OP_SPARE_7, 32'h5A5A_5A5A);
    plan_op(dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    plan_op(dq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    plan_op(dq_pkg::OP_PEEK_FRONT, 32'h0);
    plan_op(dq_pkg::OP_PEEK_BACK, 32'h0);
    plan_op(OP_SPARE_7, 32'hFFFF_FFFF);
    plan_op(dq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF);
    plan_op(dq_pkg::OP_PUSH_BACK, 32'h0000_0000);
    plan_op(dq_pkg::OP_POP_BACK, 32'h0);
    plan_op(dq_pkg::OP_POP_FRONT, 32'h0);
    plan_op(dq_pkg::OP_PEEK_FRONT, 32'h0);
    plan_op(dq_pkg::OP_POP_FRONT, 32'h0);
    plan_op(dq_pkg::OP_POP_BACK, 32'h0);
    plan_op(dq_pkg::OP_POP_BACK, 32'h0);
    plan_op(dq_pkg::OP_PEEK_BACK, 32'h0);
    plan_op(OP_SPARE_6, 32'h0);
    for (k = 0; k < 120; k++) plan_op(rand_op(45), rand_value());
    // fill to the top, then keep pushing against a full store
    while (planned_total < DEPTH) plan_op(rand_op(95), rand_value());
    for (k = 0; k < 20; k++) plan_op(rand_op(97), rand_value());
    for (k = 0; k < 130; k++) plan_op(rand_op(10), rand_value());
    for (k = 0; k < 80; k++) plan_op(rand_op(50), rand_value());

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (op_backlog.size() != 0 || in_valid) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_double_ended_queue_top: PASS");
    end else begin
      $display("tb_double_ended_queue_top: FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_double_ended_queue_top: FAIL");
      $finish;
    end
  end

  // driver: bursts of beats with random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_deque_op(in_data);
      if (!in_valid || in_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid <= 1'b0;
        end else if (op_backlog.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= op_backlog[0];
          op_backlog.delete(0);
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks result beats and drives out_ready
  always @(posedge clk) begin
    dq_pkg::out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          $error("result beat with no prediction pending");
          error_count++;
        end else begin
          want = predicted_replies[0];
          predicted_replies.delete(0);
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
            error_count++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_data.count);
            error_count++;
          end
          if (out_data.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_data.is_empty);
            error_count++;
          end
        end
        // long hold-off so the block backs up into its input
        if (replies_seen == HOLD_AT_REPLY) hold_left = HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0, 1: ready_pct = 100;
          2: ready_pct = 70;
          default: ready_pct = 25;
        endcase
      end else begin
        seg_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

endmodule
